>>> hw/rtl/cffa_pkg.sv
// ----------------------------------------------------------------------------
// cffa_pkg
// Types and constants shared by the contiguous first-fit allocator.
// ----------------------------------------------------------------------------
package cffa_pkg;

  localparam int DiskBlocks   = 128;
  localparam int TableEntries = 32;
  localparam int KeyBits      = 16;

  localparam int BlkW  = $clog2(DiskBlocks);
  localparam int CntW  = $clog2(DiskBlocks + 1);
  localparam int SlotW = $clog2(TableEntries);
  // table word: key, start, length
  localparam int EntW  = KeyBits + BlkW + CntW;

  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StTooBig    = 3'd1;
  localparam logic [2:0] StDup       = 3'd2;
  localparam logic [2:0] StNoRun     = 3'd3;
  localparam logic [2:0] StNotFound  = 3'd4;
  localparam logic [2:0] StFullOrZero = 3'd5;

  typedef struct packed {
    logic        kind;
    logic [15:0] file_key;
    logic [7:0]  block_count;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [6:0] start_block;
    logic [7:0] free_count;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TSCAN,
    S_BSCAN,
    S_MARK,
    S_DONE
  } state_e;

endpackage

>>> hw/rtl/cffa_ram.sv
// ----------------------------------------------------------------------------
// cffa_ram
// Single-port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module cffa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

>>> hw/rtl/contiguous_first_fit_allocator.sv
// ----------------------------------------------------------------------------
// contiguous_first_fit_allocator
// Contiguous first-fit block allocator with a file table.
// ----------------------------------------------------------------------------
// One request is handled at a time. Every request first walks the file table
// RAM, one slot a cycle, looking for the key and the lowest free slot. An
// insert that passes its checks then walks the block bitmap RAM one block a
// cycle until the first free run of the wanted length is found or the bitmap
// ends, and then writes the run back one block a cycle. A delete clears its
// run in the same way. The result sits in an output register; the next item
// is taken once it has been handed over. Table slot valid bits live in
// flip-flops and reset clears them at once; the bitmap is a RAM that the block
// leaves clean, so a block cleared by reset and a block freed by a delete look
// the same only after a clearing pass: after reset the block sweeps the whole
// bitmap clear before taking items.
module contiguous_first_fit_allocator (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  cffa_pkg::req_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output cffa_pkg::rsp_t  out_data_o
);
  import cffa_pkg::*;

  state_e state_q, state_d;
  req_t   req_q;
  logic [TableEntries-1:0] valid_q;
  logic [CntW-1:0] free_q;
  logic [SlotW:0]  tidx_q;          // extra bit to count past the last slot for the registered read
  logic            hit_q, empty_q;
  logic [SlotW-1:0] hit_slot_q, empty_slot_q;
  logic [BlkW-1:0] hit_start_q;
  logic [CntW-1:0] hit_len_q;
  logic [BlkW:0]   bidx_q;          // address being read
  logic [CntW-1:0] run_q;
  logic            rd_q;            // a bitmap read is in flight
  logic [BlkW:0]   mark_q;          // mark/clear address
  logic [CntW-1:0] left_q;
  logic            mark_val_q;
  logic            clr_q;           // post-reset clear pass
  logic            out_v_q;
  rsp_t            out_q;

  logic [KeyBits-1:0] key;
  req_t req_in;
  logic [EntW-1:0] t_rd, t_wd;
  logic t_we;
  logic [SlotW-1:0] t_addr;
  logic b_rd, b_wd, b_we;
  logic [BlkW-1:0] b_addr;
  logic [CntW-1:0] want;
  logic [KeyBits-1:0] e_key;
  logic [BlkW-1:0] e_start;
  logic [CntW-1:0] e_len;
  logic [SlotW-1:0] prev_slot;
  logic [BlkW-1:0] prev_blk;
  logic fin_ins, fin_del, run_hit, ins_reject;

  assign key  = in_data_i.file_key[KeyBits-1:0];
  assign want = CntW'(req_q.block_count);
  assign {e_key, e_start, e_len} = t_rd;
  assign prev_slot = SlotW'(tidx_q - 1'b1);
  assign prev_blk  = BlkW'(bidx_q - 1'b1);
  assign run_hit   = rd_q && !b_rd && (run_q + 1'b1 == want);
  // insert turned away before any bitmap work
  assign ins_reject = want > free_q || hit_q || want == '0 || !empty_q;

  // only the low key bits are kept
  always_comb begin
    req_in = in_data_i;
    req_in.file_key = 16'(key);
  end

  cffa_ram #(.Width(EntW), .Depth(TableEntries)) u_table (
    .clk_i, .we_i(t_we), .addr_i(t_addr), .wdata_i(t_wd), .rdata_o(t_rd)
  );
  cffa_ram #(.Width(1), .Depth(DiskBlocks)) u_map (
    .clk_i, .we_i(b_we), .addr_i(b_addr), .wdata_i(b_wd), .rdata_o(b_rd)
  );

  assign in_stall_o  = (state_q != S_IDLE) || out_v_q || clr_q;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i && !in_stall_o) state_d = S_TSCAN;
      S_TSCAN: if (tidx_q == (SlotW+1)'(TableEntries)) state_d = S_BSCAN;
      S_BSCAN: begin
        if (req_q.kind) state_d = hit_q ? S_MARK : S_DONE;
        else if (ins_reject) state_d = S_DONE;
        else if (run_hit) state_d = S_MARK;
        else if (bidx_q == (BlkW+1)'(DiskBlocks) && !rd_q) state_d = S_DONE;
      end
      S_MARK:  if (left_q == '0) state_d = S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // memory ports
  always_comb begin
    t_addr = tidx_q[SlotW-1:0];
    t_we   = 1'b0;
    t_wd   = {req_q.file_key[KeyBits-1:0], mark_q[BlkW-1:0] - BlkW'(want) , want};
    b_addr = bidx_q[BlkW-1:0];
    b_we   = 1'b0;
    b_wd   = mark_val_q;
    fin_ins = 1'b0;
    fin_del = 1'b0;
    if (clr_q) begin
      b_addr = mark_q[BlkW-1:0];
      b_we   = 1'b1;
      b_wd   = 1'b0;
    end else begin
      case (state_q)
        S_MARK: begin
          if (left_q != '0) begin
            b_addr = mark_q[BlkW-1:0];
            b_we   = 1'b1;
          end else begin
            t_addr = mark_val_q ? empty_slot_q : hit_slot_q;
            t_we   = mark_val_q;
            t_wd   = {req_q.file_key[KeyBits-1:0], hit_start_q, want};
            fin_ins = mark_val_q;
            fin_del = !mark_val_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      free_q  <= CntW'(DiskBlocks);
      out_v_q <= 1'b0;
      clr_q   <= 1'b1;
      mark_q  <= '0;
      rd_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_v_q && !out_stall_i) out_v_q <= 1'b0;
      if (clr_q) begin
        mark_q <= mark_q + 1'b1;
        if (mark_q == (BlkW+1)'(DiskBlocks - 1)) clr_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: if (in_valid_i && !in_stall_o) begin
          req_q <= req_in;
          tidx_q <= '0;
          hit_q <= 1'b0;
          empty_q <= 1'b0;
        end
        S_TSCAN: begin
          tidx_q <= tidx_q + 1'b1;
          if (tidx_q != '0) begin
            if (valid_q[prev_slot] && e_key == req_q.file_key[KeyBits-1:0] && !hit_q) begin
              hit_q <= 1'b1; hit_slot_q <= prev_slot;
              hit_start_q <= e_start; hit_len_q <= e_len;
            end
            if (!valid_q[prev_slot] && !empty_q) begin
              empty_q <= 1'b1; empty_slot_q <= prev_slot;
            end
          end
          bidx_q <= '0; run_q <= '0; rd_q <= 1'b0;
        end
        S_BSCAN: begin
          // settle deletes first, and decide insert rejects before scanning
          if (req_q.kind) begin
            out_q.free_count <= 8'(free_q);
            if (!hit_q) begin
              out_q.status <= StNotFound;
              out_q.start_block <= '0;
            end else begin
              out_q.status <= StOk;
              out_q.start_block <= 7'(hit_start_q);
              mark_q <= (BlkW+1)'(hit_start_q);
              left_q <= hit_len_q;
              mark_val_q <= 1'b0;
            end
          end else if (ins_reject) begin
            out_q.status <= (want > free_q) ? StTooBig : hit_q ? StDup : StFullOrZero;
            out_q.start_block <= '0;
            out_q.free_count  <= 8'(free_q);
          end else if (run_hit) begin
            hit_start_q <= BlkW'(prev_blk - BlkW'(want - 1'b1));
            mark_q <= (BlkW+1)'(prev_blk - BlkW'(want - 1'b1));
            left_q <= want;
            mark_val_q <= 1'b1;
            out_q.status <= StOk;
            out_q.start_block <= 7'(prev_blk - BlkW'(want - 1'b1));
            out_q.free_count  <= 8'(free_q - want);
          end else if (bidx_q == (BlkW+1)'(DiskBlocks) && !rd_q) begin
            out_q.status <= StNoRun;
            out_q.start_block <= '0;
            out_q.free_count  <= 8'(free_q);
          end else begin
            if (rd_q) run_q <= b_rd ? '0 : run_q + 1'b1;
            rd_q <= (bidx_q != (BlkW+1)'(DiskBlocks));
            if (bidx_q != (BlkW+1)'(DiskBlocks)) bidx_q <= bidx_q + 1'b1;
          end
        end
        S_MARK: begin
          if (left_q != '0) begin
            mark_q <= mark_q + 1'b1;
            left_q <= left_q - 1'b1;
          end else if (mark_val_q) begin
            valid_q[empty_slot_q] <= 1'b1;
            free_q <= free_q - want;
          end else begin
            valid_q[hit_slot_q] <= 1'b0;
            free_q <= free_q + hit_len_q;
            out_q.free_count <= 8'(free_q + hit_len_q);
          end
        end
        S_DONE: out_v_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // result only appears after work is done
  a_no_out_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> state_q == S_IDLE || state_q == S_TSCAN)
    else $error("result while busy");
  a_free_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= CntW'(DiskBlocks)) else $error("free count overflow");
  a_ins_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_ins |-> !valid_q[empty_slot_q]) else $error("slot reused");
  a_del_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_del |-> valid_q[hit_slot_q]) else $error("freeing empty slot");
endmodule
